// ===== rtl/bdpp_pkg.sv =====
// Package for the battery discharge power policy: request types, register indexes, reset values.
package bdpp_pkg;

    // Configuration register widths and port sizes
    localparam int unsigned CFG_DATA_W  = 8;
    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned TICK_CNT_W  = 8;
    localparam int unsigned PCT_W       = 7;
    localparam int unsigned EMPTY_CNT_W = 4;

    // Register indexes on the configuration port
    localparam logic [CFG_INDEX_W-1:0] REG_POLL_PERIOD   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_HOLD_TICKS    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_CRITICAL_PCT  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_EMPTY_PCT     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_EMPTY_SAMPLES = 3'd4;

    // Register reset values (200 ms tick, 2000 ms poll, 3000 ms hold)
    localparam logic [TICK_CNT_W-1:0]  RST_POLL_PERIOD   = 8'd10;
    localparam logic [TICK_CNT_W-1:0]  RST_HOLD_TICKS    = 8'd15;
    localparam logic [PCT_W-1:0]       RST_CRITICAL_PCT  = 7'd5;
    localparam logic [PCT_W-1:0]       RST_EMPTY_PCT     = 7'd2;
    localparam logic [EMPTY_CNT_W-1:0] RST_EMPTY_SAMPLES = 4'd3;

    // Saturation limits of the counters
    localparam logic [TICK_CNT_W-1:0]  TICK_CNT_MAX  = '1;
    localparam logic [EMPTY_CNT_W-1:0] EMPTY_CNT_MAX = '1;

    // One input request: button levels and a battery snapshot
    typedef struct packed {
        logic             button_ok;
        logic             button_left;
        logic             snapshot_valid;
        logic             pack_present;
        logic             is_charging;
        logic             external_power;
        logic             low_flag;
        logic [PCT_W-1:0] charge_percent;
    } t_in;

    // One result request
    typedef struct packed {
        logic low_warning;
        logic critical_warning;
        logic empty_shutdown;
        logic combo_shutdown;
    } t_out;

endpackage

// ===== rtl/battery_discharge_power_policy.sv =====
// Battery discharge power policy: button-hold power-off and battery poll warnings, per tick.
//
//  channel | direction | handshake                    | payload
//  --------+-----------+------------------------------+-------------------------
//  in      | to block  | i_in_valid / o_in_stall      | i_in_data  (t_in)
//  out     | from block| o_out_valid / i_out_stall    | o_out_data (t_out)
//  cfg     | to block  | i_cfg_we                     | i_cfg_index, i_cfg_data
//
//  One tick request is taken per cycle while the input is not stalled; its result is registered
//  on acceptance. The whole tick update is a single pass of counter and compare logic.
//  Reset (synchronous, active low) clears the counters and flags and loads register defaults.
//  The input stalls only while the output register holds a result that is itself stalled.
module battery_discharge_power_policy (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  bdpp_pkg::t_in                       i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output bdpp_pkg::t_out                      o_out_data,
    input  logic                                i_cfg_we,
    input  logic [bdpp_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [bdpp_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    // Configuration registers
    logic [bdpp_pkg::TICK_CNT_W-1:0]  r_poll_period;
    logic [bdpp_pkg::TICK_CNT_W-1:0]  r_hold_ticks;
    logic [bdpp_pkg::PCT_W-1:0]       r_critical_pct;
    logic [bdpp_pkg::PCT_W-1:0]       r_empty_pct;
    logic [bdpp_pkg::EMPTY_CNT_W-1:0] r_empty_samples;

    // Policy state
    logic [bdpp_pkg::TICK_CNT_W-1:0]  r_poll_cnt, n_poll_cnt;
    logic [bdpp_pkg::TICK_CNT_W-1:0]  r_hold_cnt, n_hold_cnt;
    logic                             r_low_seen, n_low_seen;
    logic                             r_crit_seen, n_crit_seen;
    logic [bdpp_pkg::EMPTY_CNT_W-1:0] r_empty_cnt, n_empty_cnt;

    // Output register
    logic           r_out_valid;
    bdpp_pkg::t_out r_out_data, n_out_data;

    logic in_accept;
    logic poll_fire;
    logic on_batt;
    logic crit_now;
    logic [bdpp_pkg::TICK_CNT_W-1:0]  hold_inc;
    logic [bdpp_pkg::TICK_CNT_W-1:0]  poll_inc;
    logic [bdpp_pkg::EMPTY_CNT_W-1:0] empty_inc;

    // Handshake: a new request may enter whenever the output slot is free or draining
    assign o_in_stall  = r_out_valid & i_out_stall;
    assign in_accept   = i_in_valid & ~o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // Configuration writes; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_poll_period   <= bdpp_pkg::RST_POLL_PERIOD;
            r_hold_ticks    <= bdpp_pkg::RST_HOLD_TICKS;
            r_critical_pct  <= bdpp_pkg::RST_CRITICAL_PCT;
            r_empty_pct     <= bdpp_pkg::RST_EMPTY_PCT;
            r_empty_samples <= bdpp_pkg::RST_EMPTY_SAMPLES;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                bdpp_pkg::REG_POLL_PERIOD:   r_poll_period   <= i_cfg_data;
                bdpp_pkg::REG_HOLD_TICKS:    r_hold_ticks    <= i_cfg_data;
                bdpp_pkg::REG_CRITICAL_PCT:  r_critical_pct  <= i_cfg_data[bdpp_pkg::PCT_W-1:0];
                bdpp_pkg::REG_EMPTY_PCT:     r_empty_pct     <= i_cfg_data[bdpp_pkg::PCT_W-1:0];
                bdpp_pkg::REG_EMPTY_SAMPLES:
                    r_empty_samples <= i_cfg_data[bdpp_pkg::EMPTY_CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Saturating increments
    assign hold_inc  = (r_hold_cnt == bdpp_pkg::TICK_CNT_MAX) ? r_hold_cnt
                                                              : r_hold_cnt + 1'b1;
    assign poll_inc  = (r_poll_cnt == bdpp_pkg::TICK_CNT_MAX) ? r_poll_cnt
                                                              : r_poll_cnt + 1'b1;
    assign empty_inc = (r_empty_cnt == bdpp_pkg::EMPTY_CNT_MAX) ? r_empty_cnt
                                                                : r_empty_cnt + 1'b1;

    assign poll_fire = poll_inc >= r_poll_period;
    assign on_batt   = i_in_data.pack_present & ~i_in_data.is_charging
                     & ~i_in_data.external_power;
    assign crit_now  = on_batt & (i_in_data.charge_percent <= r_critical_pct);

    // One tick of the policy
    always_comb begin
        n_hold_cnt  = r_hold_cnt;
        n_poll_cnt  = r_poll_cnt;
        n_low_seen  = r_low_seen;
        n_crit_seen = r_crit_seen;
        n_empty_cnt = r_empty_cnt;
        n_out_data  = '0;

        // button combination hold timer
        if (i_in_data.button_ok && i_in_data.button_left) begin
            if (hold_inc >= r_hold_ticks) begin
                n_hold_cnt                = '0;
                n_out_data.combo_shutdown = 1'b1;
            end else begin
                n_hold_cnt = hold_inc;
            end
        end else begin
            n_hold_cnt = '0;
        end

        // poll divider and battery checks
        n_poll_cnt = poll_fire ? '0 : poll_inc;
        if (poll_fire && i_in_data.snapshot_valid) begin
            n_out_data.low_warning      = i_in_data.low_flag & ~r_low_seen;
            n_low_seen                  = i_in_data.low_flag;
            n_out_data.critical_warning = crit_now & ~r_crit_seen;
            n_crit_seen                 = crit_now;
            if (on_batt && (i_in_data.charge_percent <= r_empty_pct)) begin
                n_empty_cnt               = empty_inc;
                n_out_data.empty_shutdown = empty_inc >= r_empty_samples;
            end else begin
                n_empty_cnt = '0;
            end
        end
    end

    // State update on each accepted tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_poll_cnt  <= '0;
            r_hold_cnt  <= '0;
            r_low_seen  <= 1'b0;
            r_crit_seen <= 1'b0;
            r_empty_cnt <= '0;
        end else if (in_accept) begin
            r_poll_cnt  <= n_poll_cnt;
            r_hold_cnt  <= n_hold_cnt;
            r_low_seen  <= n_low_seen;
            r_crit_seen <= n_crit_seen;
            r_empty_cnt <= n_empty_cnt;
        end
    end

    // Output register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out_data <= n_out_data;
        end
    end

    // Checks
    a_combo_clears_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && n_out_data.combo_shutdown |=> r_hold_cnt == '0)
        else $error("hold count not cleared after combo shutdown");

    a_no_poll_keeps_battery: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && !poll_fire |=> $stable(r_low_seen) && $stable(r_crit_seen)
                                    && $stable(r_empty_cnt))
        else $error("battery state changed without a poll");

    a_empty_sd_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && n_out_data.empty_shutdown |=> r_empty_cnt != '0)
        else $error("empty shutdown with empty poll count at zero");

    a_crit_marks_seen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && n_out_data.critical_warning |=> r_crit_seen)
        else $error("critical warning without critical state recorded");

    a_stall_needs_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_out_valid)
        else $error("input stalled while output register empty");

endmodule

// ===== dv/battery_discharge_power_policy_tb.sv =====
// Testbench for battery_discharge_power_policy: table-driven and random ticks vs a predictor.
`timescale 1ns / 1ps

module battery_discharge_power_policy_tb;

    // Register indexes that decode to nothing
    localparam logic [bdpp_pkg::CFG_INDEX_W-1:0] REG_IDX_NONE_LO = 3'd5;
    localparam logic [bdpp_pkg::CFG_INDEX_W-1:0] REG_IDX_NONE_HI = 3'd7;

    localparam int TICKS_PER_PHASE = 100;
    localparam int NUM_PHASES      = 8;
    localparam int LONG_HOLD       = 80;
    localparam int DRAIN_PAUSE     = 4;

    typedef enum logic {STEP_TICK, STEP_WRITE} t_step_kind;

    // One row of the directed table: a tick request or a register write
    typedef struct {
        t_step_kind                           kind;
        bdpp_pkg::t_in                        req;
        logic [bdpp_pkg::CFG_INDEX_W-1:0]     idx;
        logic [bdpp_pkg::CFG_DATA_W-1:0]      val;
        logic                                 fixed;
        bdpp_pkg::t_out                       res;
    } t_dir_row;

    logic                             clk       = 1'b0;
    logic                             rst_n     = 1'b0;
    logic                             in_valid  = 1'b0;
    logic                             in_stall;
    bdpp_pkg::t_in                    in_data   = '0;
    logic                             out_valid;
    logic                             out_stall = 1'b0;
    bdpp_pkg::t_out                   out_data;
    logic                             cfg_we    = 1'b0;
    logic [bdpp_pkg::CFG_INDEX_W-1:0] cfg_idx   = '0;
    logic [bdpp_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;

    // Predictor copy of registers and state
    logic [bdpp_pkg::TICK_CNT_W-1:0]  cfg_period;
    logic [bdpp_pkg::TICK_CNT_W-1:0]  cfg_hold;
    logic [bdpp_pkg::PCT_W-1:0]       cfg_crit;
    logic [bdpp_pkg::PCT_W-1:0]       cfg_empty;
    logic [bdpp_pkg::EMPTY_CNT_W-1:0] cfg_samples;
    logic [bdpp_pkg::TICK_CNT_W-1:0]  poll_cnt;
    logic [bdpp_pkg::TICK_CNT_W-1:0]  hold_cnt;
    logic                             low_seen_q;
    logic                             crit_seen_q;
    logic [bdpp_pkg::EMPTY_CNT_W-1:0] empty_cnt;

    bdpp_pkg::t_out pending_results[$];
    t_dir_row       dir_tab[$];
    int             err_cnt      = 0;
    int             snd_idle     = 0;
    int             rcv_idle     = 0;
    int             hold_req_cnt = 0;
    int             hold_seen    = 0;
    int             hold_left    = 0;

    // Random stimulus shaping state
    int                         btn_run       = 0;
    logic                       scene_present = 1'b1;
    logic                       scene_chg     = 1'b0;
    logic                       scene_ext     = 1'b0;
    logic                       scene_low     = 1'b0;
    logic [bdpp_pkg::PCT_W-1:0] scene_pct     = '0;

    battery_discharge_power_policy dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // Run limit
    initial begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // One tick of the policy: advances the predictor state, returns the expected result
    function automatic bdpp_pkg::t_out predict_tick(input bdpp_pkg::t_in r);
        bdpp_pkg::t_out res;
        logic on_batt;
        logic crit;
        res = '0;
        // button combination hold
        if (r.button_ok && r.button_left) begin
            if (hold_cnt != bdpp_pkg::TICK_CNT_MAX) hold_cnt++;
            if (hold_cnt >= cfg_hold) begin
                hold_cnt = '0;
                res.combo_shutdown = 1'b1;
            end
        end else begin
            hold_cnt = '0;
        end
        // poll divider and battery evaluation
        if (poll_cnt != bdpp_pkg::TICK_CNT_MAX) poll_cnt++;
        if (poll_cnt >= cfg_period) begin
            poll_cnt = '0;
            if (r.snapshot_valid) begin
                on_batt = r.pack_present && !r.is_charging && !r.external_power;
                res.low_warning = r.low_flag && !low_seen_q;
                low_seen_q = r.low_flag;
                crit = on_batt && (r.charge_percent <= cfg_crit);
                res.critical_warning = crit && !crit_seen_q;
                crit_seen_q = crit;
                if (on_batt && (r.charge_percent <= cfg_empty)) begin
                    if (empty_cnt != bdpp_pkg::EMPTY_CNT_MAX) empty_cnt++;
                    res.empty_shutdown = (empty_cnt >= cfg_samples);
                end else begin
                    empty_cnt = '0;
                end
            end
        end
        return res;
    endfunction

    // Random tick request: button hold runs with noise, a battery scene that drifts
    function automatic bdpp_pkg::t_in gen_req();
        bdpp_pkg::t_in r;
        r = '0;
        if (btn_run == 0 && $urandom_range(99) < 55)
            btn_run = $urandom_range(int'(cfg_hold) + 2, 1);
        if (btn_run > 0) begin
            r.button_ok   = 1'b1;
            r.button_left = 1'b1;
            btn_run--;
        end else begin
            r.button_ok   = 1'($urandom_range(1));
            r.button_left = 1'($urandom_range(1));
        end
        if ($urandom_range(99) < 10) begin
            scene_present = ($urandom_range(99) < 85);
            scene_chg     = ($urandom_range(99) < 15);
            scene_ext     = ($urandom_range(99) < 15);
            case ($urandom_range(3))
                0: scene_pct = cfg_crit + 7'($urandom_range(2)) - 7'd1;
                1: scene_pct = cfg_empty + 7'($urandom_range(2)) - 7'd1;
                2: scene_pct = 7'($urandom_range(2));
                default: scene_pct = 7'($urandom_range(127));
            endcase
        end
        if ($urandom_range(99) < 20) scene_low = ~scene_low;
        r.snapshot_valid = ($urandom_range(99) < 85);
        r.pack_present   = scene_present;
        r.is_charging    = scene_chg;
        r.external_power = scene_ext;
        r.low_flag       = scene_low;
        r.charge_percent = scene_pct;
        return r;
    endfunction

    // Offer one request, wait for acceptance, queue its expected result
    task automatic send_req(input bdpp_pkg::t_in req, input logic fixed,
                            input bdpp_pkg::t_out res);
        bdpp_pkg::t_out want;
        if ($urandom_range(99) < snd_idle) begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < snd_idle) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        want = predict_tick(req);
        if (fixed) want = res;
        pending_results.push_back(want);
    endtask

    // Stop offering and wait until every result is back
    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (DRAIN_PAUSE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [bdpp_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [bdpp_pkg::CFG_DATA_W-1:0] val);
        drain_results();
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we   <= 1'b0;
        case (idx)
            bdpp_pkg::REG_POLL_PERIOD:   cfg_period  = val;
            bdpp_pkg::REG_HOLD_TICKS:    cfg_hold    = val;
            bdpp_pkg::REG_CRITICAL_PCT:  cfg_crit    = val[bdpp_pkg::PCT_W-1:0];
            bdpp_pkg::REG_EMPTY_PCT:     cfg_empty   = val[bdpp_pkg::PCT_W-1:0];
            bdpp_pkg::REG_EMPTY_SAMPLES: cfg_samples = val[bdpp_pkg::EMPTY_CNT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic add_tick(input bdpp_pkg::t_in req, input logic fixed,
                            input bdpp_pkg::t_out res);
        t_dir_row row;
        row.kind  = STEP_TICK;
        row.req   = req;
        row.idx   = '0;
        row.val   = '0;
        row.fixed = fixed;
        row.res   = res;
        dir_tab.push_back(row);
    endtask

    task automatic add_write(input logic [bdpp_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [bdpp_pkg::CFG_DATA_W-1:0] val);
        t_dir_row row;
        row.kind  = STEP_WRITE;
        row.req   = '0;
        row.idx   = idx;
        row.val   = val;
        row.fixed = 1'b0;
        row.res   = '0;
        dir_tab.push_back(row);
    endtask

    // Result side: check accepted results, drive stall with random gaps and long holds
    always @(posedge clk) begin : rx_side
        bdpp_pkg::t_out want;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_results.size() == 0) begin
                $error("result %b with nothing outstanding", out_data);
                err_cnt++;
            end else begin
                want = pending_results.pop_front();
                if (out_data.low_warning !== want.low_warning) begin
                    $error("low_warning: expected %b, got %b",
                           want.low_warning, out_data.low_warning);
                    err_cnt++;
                end
                if (out_data.critical_warning !== want.critical_warning) begin
                    $error("critical_warning: expected %b, got %b",
                           want.critical_warning, out_data.critical_warning);
                    err_cnt++;
                end
                if (out_data.empty_shutdown !== want.empty_shutdown) begin
                    $error("empty_shutdown: expected %b, got %b",
                           want.empty_shutdown, out_data.empty_shutdown);
                    err_cnt++;
                end
                if (out_data.combo_shutdown !== want.combo_shutdown) begin
                    $error("combo_shutdown: expected %b, got %b",
                           want.combo_shutdown, out_data.combo_shutdown);
                    err_cnt++;
                end
            end
        end
        if (hold_req_cnt != hold_seen) begin
            hold_seen = hold_req_cnt;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            out_stall <= 1'b1;
            hold_left--;
        end else begin
            out_stall <= ($urandom_range(99) < rcv_idle);
        end
    end

    // Stimulus: directed table, then random phases under several register settings
    initial begin : stim
        t_dir_row row;
        int k;
        int ph;
        logic [bdpp_pkg::CFG_DATA_W-1:0] p, h, c, e, s;

        cfg_period  = bdpp_pkg::RST_POLL_PERIOD;
        cfg_hold    = bdpp_pkg::RST_HOLD_TICKS;
        cfg_crit    = bdpp_pkg::RST_CRITICAL_PCT;
        cfg_empty   = bdpp_pkg::RST_EMPTY_PCT;
        cfg_samples = bdpp_pkg::RST_EMPTY_SAMPLES;
        poll_cnt    = '0;
        hold_cnt    = '0;
        low_seen_q  = 1'b0;
        crit_seen_q = 1'b0;
        empty_cnt   = '0;

        // Flags: ok, left, valid, present, charging, external, low; then percent.
        // Results: low, critical, empty, combo.
        add_tick({7'b0000000, 7'd0}, 1'b1, 4'b0000);      // first tick after reset
        add_tick({7'b1111001, 7'd0}, 1'b0, '0);
        // fastest settings, widest thresholds; writes to unused indexes
        add_write(bdpp_pkg::REG_POLL_PERIOD, 8'd1);
        add_write(bdpp_pkg::REG_HOLD_TICKS, 8'd1);
        add_write(bdpp_pkg::REG_CRITICAL_PCT, 8'd100);
        add_write(bdpp_pkg::REG_EMPTY_PCT, 8'd100);
        add_write(bdpp_pkg::REG_EMPTY_SAMPLES, 8'd1);
        add_write(REG_IDX_NONE_LO, 8'hFF);
        add_write(REG_IDX_NONE_HI, 8'h00);
        add_tick({7'b1111001, 7'd0}, 1'b1, 4'b1111);      // everything fires at once
        add_tick({7'b1111001, 7'd0}, 1'b1, 4'b0011);      // edges gone, levels remain
        add_tick({7'b0000000, 7'd127}, 1'b1, 4'b0000);    // invalid snapshot on a poll
        add_tick({7'b1011100, 7'd0}, 1'b0, '0);           // charging
        add_tick({7'b0110011, 7'd0}, 1'b0, '0);           // external supply
        add_tick({7'b0010001, 7'd0}, 1'b0, '0);           // no pack
        add_tick({7'b0011000, 7'd100}, 1'b0, '0);         // right at the threshold
        add_tick({7'b0011000, 7'd101}, 1'b0, '0);         // above 100 percent
        // zero registers: the poll fires on every tick, the hold on every tick with both buttons down
        add_write(bdpp_pkg::REG_POLL_PERIOD, 8'd0);
        add_write(bdpp_pkg::REG_HOLD_TICKS, 8'd0);
        add_write(bdpp_pkg::REG_CRITICAL_PCT, 8'd0);
        add_write(bdpp_pkg::REG_EMPTY_PCT, 8'd0);
        add_write(bdpp_pkg::REG_EMPTY_SAMPLES, 8'd0);
        add_tick({7'b1111001, 7'd0}, 1'b0, '0);
        add_tick({7'b1111001, 7'd1}, 1'b0, '0);
        add_tick({7'b0011000, 7'd0}, 1'b0, '0);
        // all-ones data, masked to register widths
        add_write(bdpp_pkg::REG_POLL_PERIOD, 8'hFF);
        add_write(bdpp_pkg::REG_HOLD_TICKS, 8'hFF);
        add_write(bdpp_pkg::REG_CRITICAL_PCT, 8'hFF);
        add_write(bdpp_pkg::REG_EMPTY_PCT, 8'hFF);
        add_write(bdpp_pkg::REG_EMPTY_SAMPLES, 8'hFF);
        add_tick({7'b1111001, 7'd127}, 1'b0, '0);
        add_tick({7'b1111001, 7'd127}, 1'b0, '0);
        add_tick({7'b1100000, 7'd64}, 1'b0, '0);
        // back to reset values
        add_write(bdpp_pkg::REG_POLL_PERIOD, bdpp_pkg::RST_POLL_PERIOD);
        add_write(bdpp_pkg::REG_HOLD_TICKS, bdpp_pkg::RST_HOLD_TICKS);
        add_write(bdpp_pkg::REG_CRITICAL_PCT, 8'(bdpp_pkg::RST_CRITICAL_PCT));
        add_write(bdpp_pkg::REG_EMPTY_PCT, 8'(bdpp_pkg::RST_EMPTY_PCT));
        add_write(bdpp_pkg::REG_EMPTY_SAMPLES, 8'(bdpp_pkg::RST_EMPTY_SAMPLES));
        add_tick({7'b1111001, 7'd3}, 1'b0, '0);

        snd_idle = 23;
        rcv_idle = 65;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (k = 0; k < dir_tab.size(); k++) begin
            row = dir_tab[k];
            if (row.kind == STEP_WRITE) write_reg(row.idx, row.val);
            else send_req(row.req, row.fixed, row.res);
        end

        for (ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0: begin p = 8'd1; h = 8'd3; c = 8'd20; e = 8'd10; s = 8'd2; end
                1: begin p = 8'd1; h = 8'd1; c = 8'd50; e = 8'd50; s = 8'd15; end
                3: begin p = 8'd0; h = 8'd0; c = 8'd0; e = 8'd0; s = 8'd0; end
                4: begin p = 8'hFF; h = 8'hFF; c = 8'hFF; e = 8'hFF; s = 8'hFF; end
                default: begin
                    p = 8'($urandom_range(6));
                    h = 8'($urandom_range(8));
                    c = 8'($urandom_range(127));
                    e = 8'($urandom_range(60));
                    s = 8'($urandom_range(15));
                end
            endcase
            write_reg(bdpp_pkg::REG_POLL_PERIOD, p);
            write_reg(bdpp_pkg::REG_HOLD_TICKS, h);
            write_reg(bdpp_pkg::REG_CRITICAL_PCT, c);
            write_reg(bdpp_pkg::REG_EMPTY_PCT, e);
            write_reg(bdpp_pkg::REG_EMPTY_SAMPLES, s);
            write_reg(3'($urandom_range(REG_IDX_NONE_HI, REG_IDX_NONE_LO)),
                      8'($urandom_range(255)));

            if (ph < 3) begin
                snd_idle = 23;
                rcv_idle = 65;
            end else if (ph < 6) begin
                snd_idle = 65;
                rcv_idle = 23;
            end else begin
                snd_idle = 0;
                rcv_idle = 0;
            end

            for (k = 0; k < TICKS_PER_PHASE; k++) begin
                if (k == TICKS_PER_PHASE / 2) begin
                    // sender pauses until all results are in
                    if (ph == 3) drain_results();
                    // receiver holds off while requests keep coming
                    if (ph == 6) hold_req_cnt++;
                end
                send_req(gen_req(), 1'b0, '0);
            end
        end

        drain_results();
        if (err_cnt == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
